/* rtl/core/wsfc_pkg.sv */
`default_nettype none
package wsfc_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int KIND_W   = 2;
  localparam int SEG_W    = 32;
  localparam int WIN_W    = 6;
  localparam int THR_W    = 4;
  localparam int FLIGHT_W = 8;
  localparam int ACT_W    = 2;
  localparam int ETO_W    = 2;
  localparam int CNT_W    = 6;
  localparam int CFG_IDX_W = 2;

  // stream widths
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 6;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;

  // commands
  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  // content kinds
  localparam logic [KIND_W-1:0] KIND_CONTENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NACK    = 2'd1;

  // result actions
  localparam logic [ACT_W-1:0] ACT_SEND   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RETX   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STATUS = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_THR   = 2'd2;

  // register reset values
  localparam logic [WIN_W-1:0] MIN_WINDOW_RST = 6'd1;
  localparam logic [WIN_W-1:0] MAX_WINDOW_RST = 6'd32;
  localparam logic [THR_W-1:0] FAST_THR_RST   = 4'd3;

  // limits
  localparam logic [CNT_W-1:0]    MAX_FAST_RETX = 6'd31;
  localparam logic [CNT_W-1:0]    MAX_BODY      = 6'd63;
  localparam logic [ETO_W-1:0]    TIMEOUT_LIMIT = 2'd2;
  localparam logic [FLIGHT_W-1:0] FLIGHT_MAX    = 8'd255;

  // parameter defaults
  localparam int TRACK_DEPTH_DEF  = 1024;
  localparam int WINDOW_LIMIT_DEF = 32;
  localparam int SEG_BITS_DEF     = 32;

endpackage
`default_nettype wire

/* rtl/core/wsfc_map.sv */
`default_nettype none
module wsfc_map #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [1:0]               wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [1:0]               rdata
);

  // bit 0 received, bit 1 retransmitted
  logic [1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/wsfc_ctrl.sv */
`default_nettype none
module wsfc_ctrl #(
  parameter int TRACK_DEPTH  = wsfc_pkg::TRACK_DEPTH_DEF,
  parameter int WINDOW_LIMIT = wsfc_pkg::WINDOW_LIMIT_DEF,
  parameter int SEG_BITS     = wsfc_pkg::SEG_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [wsfc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  wire logic [wsfc_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [wsfc_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic      [wsfc_pkg::OUT_USER_W-1:0]    m_tuser,
  output logic                                    m_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [wsfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wsfc_pkg::WIN_W-1:0]         cfg_data
);
  import wsfc_pkg::*;

  localparam int IDX_W = $clog2(TRACK_DEPTH);
  localparam int TOT_W = IDX_W + 1;
  localparam int CMP_W = (SEG_BITS > SEG_W) ? SEG_BITS : SEG_W;
  localparam int CAP_W = 8;
  localparam logic [CAP_W-1:0] WIN_LIM = CAP_W'(WINDOW_LIMIT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TRACK_DEPTH - 1);
  localparam logic [SEG_W-1:0] DEPTH_SEG = SEG_W'(TRACK_DEPTH);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_SEND0 = 4'd2;
  localparam logic [3:0] ST_UPD   = 4'd3;
  localparam logic [3:0] ST_MARK  = 4'd4;
  localparam logic [3:0] ST_CRD   = 4'd5;
  localparam logic [3:0] ST_CCHK  = 4'd6;
  localparam logic [3:0] ST_SRD   = 4'd7;
  localparam logic [3:0] ST_SCHK  = 4'd8;
  localparam logic [3:0] ST_FILL  = 4'd9;
  localparam logic [3:0] ST_STAT  = 4'd10;

  logic [3:0] state;

  // configuration
  logic [WIN_W-1:0] min_window;
  logic [WIN_W-1:0] max_window;
  logic [THR_W-1:0] fast_thr;

  // latched event
  logic [CMD_W-1:0]  cmd;
  logic [SEG_W-1:0]  seg;
  logic              verified;
  logic [KIND_W-1:0] kind;
  logic              has_final;
  logic [SEG_W-1:0]  fin;

  // fetch state
  logic                active;
  logic                final_known;
  logic [SEG_BITS-1:0] final_block;
  logic [SEG_BITS-1:0] next_segment;
  logic [FLIGHT_W-1:0] in_flight;
  logic [WIN_W-1:0]    cur_window;
  logic [ETO_W-1:0]    early_timeouts;
  logic [IDX_W-1:0]    highest;

  // scan state
  logic [IDX_W-1:0] idx;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] before_cnt;
  logic [CNT_W-1:0] sent;
  logic [CNT_W-1:0] n_items;

  // map port
  logic             map_we;
  logic [IDX_W-1:0] map_waddr;
  logic [1:0]       map_wdata;
  logic             map_re;
  logic [1:0]       map_rdata;

  // output slot
  logic             slot_free;
  logic             emit;
  logic [ACT_W-1:0] emit_act;
  logic [SEG_W-1:0] emit_seg;
  logic             emit_last;

  // event arithmetic
  logic [CAP_W-1:0]    cap;
  logic [WIN_W-1:0]    halved;
  logic [WIN_W-1:0]    win_upd;
  logic                fk_upd;
  logic [SEG_BITS-1:0] fb_upd;
  logic [CMP_W-1:0]    seg_ext;
  logic [CMP_W-1:0]    fb_ext;
  logic [CMP_W-1:0]    next_ext;
  logic [CMP_W-1:0]    fin_ext;
  logic [FLIGHT_W-1:0] flight_dec;
  logic [FLIGHT_W-1:0] flight_inc;
  logic [ETO_W-1:0]    eto_inc;
  logic [IDX_W-1:0]    seg_idx;
  logic                seg_tracked;
  logic                retx_hit;
  logic                scan_end;
  logic                can_send;
  logic [TOT_W-1:0]    above;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_window <= MIN_WINDOW_RST;
      max_window <= MAX_WINDOW_RST;
      fast_thr   <= FAST_THR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_WINDOW: min_window <= cfg_data;
        REG_MAX_WINDOW: max_window <= cfg_data;
        REG_FAST_THR:   fast_thr   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cap = ({2'b0, max_window} < WIN_LIM) ? {2'b0, max_window} : WIN_LIM;
    halved = cur_window >> 1;
    if (halved == '0) begin
      halved = WIN_W'(1);
    end
    win_upd = cur_window;
    fk_upd  = final_known;
    fb_upd  = final_block;
    fin_ext = CMP_W'(fin);
    if (cmd == CMD_DATA) begin
      if (verified) begin
        if (kind == KIND_CONTENT) begin
          if ({2'b0, cur_window} < cap) begin
            win_upd = cur_window + WIN_W'(1);
          end
          if (has_final) begin
            fk_upd = 1'b1;
            fb_upd = fin_ext[SEG_BITS-1:0];
          end
        end else if (kind == KIND_NACK) begin
          if (cur_window > min_window) begin
            win_upd = halved;
          end
        end
      end
    end else if (cur_window > min_window) begin
      win_upd = halved;
    end
    seg_ext     = CMP_W'(seg);
    fb_ext      = CMP_W'(fb_upd);
    next_ext    = CMP_W'(next_segment);
    flight_dec  = (in_flight != '0) ? in_flight - FLIGHT_W'(1) : in_flight;
    flight_inc  = (in_flight != FLIGHT_MAX) ? in_flight + FLIGHT_W'(1) : in_flight;
    eto_inc     = early_timeouts + ETO_W'(1);
    seg_idx     = seg[IDX_W-1:0];
    seg_tracked = seg < DEPTH_SEG;
    above       = total - before_cnt;
    retx_hit    = !map_rdata[0] && !map_rdata[1] && (above >= TOT_W'(fast_thr));
    scan_end    = (idx == highest);
    can_send    = active && ({2'b0, in_flight} < {4'b0, cur_window} + 10'd0 ? 1'b1 : 1'b0)
                  && (n_items < MAX_BODY)
                  && !(final_known && (next_ext > CMP_W'(final_block)));
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = idx;
    map_wdata = 2'b00;
    map_re    = 1'b0;
    emit      = 1'b0;
    emit_act  = ACT_STATUS;
    emit_seg  = '0;
    emit_last = 1'b0;
    case (state)
      ST_CLEAR: begin
        map_we = 1'b1;
      end
      ST_SEND0: begin
        emit     = slot_free;
        emit_act = ACT_SEND;
        emit_seg = next_ext[SEG_W-1:0];
      end
      ST_MARK: begin
        map_we    = 1'b1;
        map_waddr = seg_idx;
        map_wdata = 2'b01;
      end
      ST_CRD, ST_SRD: begin
        map_re = 1'b1;
      end
      ST_SCHK: begin
        if (!map_rdata[0] && retx_hit && slot_free) begin
          emit      = 1'b1;
          emit_act  = ACT_RETX;
          emit_seg  = SEG_W'(idx);
          map_we    = 1'b1;
          map_wdata = 2'b10;
        end
      end
      ST_FILL: begin
        if (can_send) begin
          emit     = slot_free;
          emit_act = ACT_SEND;
          emit_seg = next_ext[SEG_W-1:0];
        end
      end
      ST_STAT: begin
        emit      = slot_free;
        emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {2'b0, cur_window, emit_seg};
      m_tuser <= {active, emit_act};
      m_tlast <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd       <= s_tuser[1:0];
      kind      <= s_tuser[3:2];
      verified  <= s_tuser[4];
      has_final <= s_tuser[5];
      seg       <= s_tdata[SEG_W-1:0];
      fin       <= s_tdata[2*SEG_W-1:SEG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      active         <= 1'b0;
      final_known    <= 1'b0;
      final_block    <= '1;
      next_segment   <= '0;
      in_flight      <= '0;
      cur_window     <= '0;
      early_timeouts <= '0;
      highest        <= '0;
      idx            <= '0;
      total          <= '0;
      before_cnt     <= '0;
      sent           <= '0;
      n_items        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          n_items <= '0;
          idx     <= '0;
          if (s_tvalid) begin
            if (s_tuser[1:0] == CMD_START) begin
              state <= ST_CLEAR;
            end else if ((s_tuser[1:0] == CMD_DATA || s_tuser[1:0] == CMD_TIMEOUT)
                         && active) begin
              state <= ST_UPD;
            end else begin
              state <= ST_STAT;
            end
          end
        end
        ST_CLEAR: begin
          idx <= idx + IDX_W'(1);
          if (idx == IDX_LAST) begin
            active         <= 1'b1;
            final_known    <= 1'b0;
            final_block    <= '1;
            next_segment   <= '0;
            in_flight      <= '0;
            cur_window     <= '0;
            early_timeouts <= '0;
            highest        <= '0;
            state          <= ST_SEND0;
          end
        end
        ST_SEND0: begin
          if (emit) begin
            in_flight    <= flight_inc;
            next_segment <= next_segment + SEG_BITS'(1);
            state        <= ST_STAT;
          end
        end
        ST_UPD: begin
          in_flight   <= flight_dec;
          cur_window  <= win_upd;
          final_known <= fk_upd;
          final_block <= fb_upd;
          state       <= ST_FILL;
          if (cmd == CMD_DATA) begin
            if (fk_upd && seg_ext >= fb_ext) begin
              active <= 1'b0;
            end
            if (verified && seg_tracked) begin
              state <= ST_MARK;
            end
          end else if (!final_known) begin
            early_timeouts <= eto_inc;
            if (eto_inc > TIMEOUT_LIMIT) begin
              active <= 1'b0;
            end
          end
        end
        ST_MARK: begin
          if (seg_idx > highest) begin
            highest <= seg_idx;
          end
          idx        <= '0;
          total      <= '0;
          before_cnt <= '0;
          sent       <= '0;
          state      <= (fast_thr == '0) ? ST_FILL : ST_CRD;
        end
        ST_CRD: begin
          state <= ST_CCHK;
        end
        ST_CCHK: begin
          total <= total + TOT_W'(map_rdata[0]);
          if (scan_end) begin
            idx   <= '0;
            state <= ST_SRD;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= ST_CRD;
          end
        end
        ST_SRD: begin
          state <= ST_SCHK;
        end
        ST_SCHK: begin
          if (map_rdata[0] || !retx_hit || slot_free) begin
            if (map_rdata[0]) begin
              before_cnt <= before_cnt + TOT_W'(1);
            end
            if (emit) begin
              in_flight <= flight_inc;
              sent      <= sent + CNT_W'(1);
              n_items   <= n_items + CNT_W'(1);
            end
            if (scan_end || (emit && sent + CNT_W'(1) == MAX_FAST_RETX)) begin
              state <= ST_FILL;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= ST_SRD;
            end
          end
        end
        ST_FILL: begin
          if (!can_send) begin
            state <= ST_STAT;
          end else if (emit) begin
            in_flight    <= flight_inc;
            next_segment <= next_segment + SEG_BITS'(1);
            n_items      <= n_items + CNT_W'(1);
          end
        end
        ST_STAT: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  wsfc_map #(
    .DEPTH(TRACK_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (idx),
    .rdata (map_rdata)
  );

endmodule
`default_nettype wire

/* rtl/core/windowed_segment_fetch_control_top.sv */
`default_nettype none
// segment fetch controller with an aimd congestion window and fast retransmit.
// events come in on the slave stream, one at a time; each event yields zero or
// more request transfers (send or fast retransmit) followed by one status
// transfer flagged with tlast. every transfer of an event carries the running
// flag and the window as they stand after that event. a start event sweeps the
// received/retransmitted bitmap memory one entry per cycle. a data event with
// tracked, verified data marks it and, unless the fast retransmit threshold is
// zero, walks the bitmap twice (count, then gap scan), reading then checking
// each entry up to the highest received segment; the gap scan stops early at
// the fast retransmit limit. running data/timeout events refill the window.
// output stalls hold the sequencer in place. the input is ready only between
// events, while the last status transfer may still sit in the output register.
module windowed_segment_fetch_control_top #(
  parameter int TRACK_DEPTH  = wsfc_pkg::TRACK_DEPTH_DEF,
  parameter int WINDOW_LIMIT = wsfc_pkg::WINDOW_LIMIT_DEF,
  parameter int SEG_BITS     = wsfc_pkg::SEG_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // segment[31:0], final_segment[63:32]
  input  wire logic [wsfc_pkg::IN_DATA_W-1:0]  s_tdata,
  // command[1:0], content_kind[3:2], verified[4], has_final[5]
  input  wire logic [wsfc_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // request_segment[31:0], window[37:32], zero pad [39:38]
  output logic      [wsfc_pkg::OUT_DATA_W-1:0] m_tdata,
  // action[1:0], running[2]
  output logic      [wsfc_pkg::OUT_USER_W-1:0] m_tuser,
  output logic                                 m_tlast,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  // 0 min_window, 1 max_window, 2 fast_retx_threshold
  input  wire logic [wsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [wsfc_pkg::WIN_W-1:0]      cfg_data
);

  wsfc_ctrl #(
    .TRACK_DEPTH  (TRACK_DEPTH),
    .WINDOW_LIMIT (WINDOW_LIMIT),
    .SEG_BITS     (SEG_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
`default_nettype wire
